### hdl/dcwg_pkg.sv
`timescale 1ns / 1ps

package dcwg_pkg;

   localparam int MAX_CHANNELS_DEFAULT     = 16;
   localparam int MAX_INPUT_WIDTH_DEFAULT  = 1024;
   localparam int MAX_KERNEL_WIDTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_GRAD  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_CHANNELS = 2'd0,
      CSR_WIDTH    = 2'd1,
      CSR_KERNEL   = 2'd2,
      CSR_STRIDE   = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      FP_ZERO   = 2'd0,
      FP_NORMAL = 2'd1,
      FP_INF    = 2'd2,
      FP_NAN    = 2'd3
   } fp_class_type;

   // A single-precision operand with subnormals normalized: value = sig * 2^(exp - 23),
   // where exp is a two's complement exponent and sig has its top bit set.
   typedef struct packed {
      fp_class_type cls;
      logic         sign;
      logic [9:0]   exp;
      logic [23:0]  sig;
      logic [63:0]  nan_bits;
   } fp32_unpacked_type;

   localparam logic [63:0] FP64_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;

   function automatic fp32_unpacked_type fp32_unpack(input logic [31:0] bits);
      fp32_unpacked_type r;
      logic [7:0]        e;
      logic [22:0]       f;
      logic [23:0]       sig;
      logic [4:0]        lz;
      logic signed [9:0] eb;
      e  = bits[30:23];
      f  = bits[22:0];
      sig = {(e != 8'd0), f};
      lz = 5'd0;
      for (int i = 0; i < 24; i++) begin
         if (sig[i]) begin
            lz = 5'(23 - i);
         end
      end
      eb = (e == 8'd0) ? -10'sd126 : ($signed({2'b00, e}) - 10'sd127);
      r.sign     = bits[31];
      r.sig      = sig << lz;
      r.exp      = 10'(eb - $signed({5'd0, lz}));
      // Widening a NaN keeps its payload and makes it quiet.
      r.nan_bits = {bits[31], 11'h7FF, 1'b1, f[21:0], 29'd0};
      if (e == 8'hFF) begin
         r.cls = (f == 23'd0) ? FP_INF : FP_NAN;
      end else if (e == 8'd0 && f == 23'd0) begin
         r.cls = FP_ZERO;
      end else begin
         r.cls = FP_NORMAL;
      end
      return r;
   endfunction

   // Double to single conversion, round to nearest even.
   function automatic logic [31:0] fp64_to_fp32(input logic [63:0] a);
      logic               s;
      logic [10:0]        e;
      logic [51:0]        f;
      logic signed [12:0] ue;
      logic [5:0]         sh;
      logic [52:0]        sig;
      logic [52:0]        q;
      logic               g;
      logic               st;
      logic               up;
      logic [30:0]        body;
      s   = a[63];
      e   = a[62:52];
      f   = a[51:0];
      ue  = $signed({2'b00, e}) - 13'sd1023;
      sh  = 6'(-13'sd97 - ue);
      sig = {1'b1, f};
      q   = 53'd0;
      g   = 1'b0;
      st  = 1'b0;
      up  = 1'b0;
      body = 31'd0;
      if (e == 11'h7FF) begin
         body = (f != 52'd0) ? {8'hFF, 1'b1, f[50:29]} : {8'hFF, 23'd0};
      end else if (e == 11'd0) begin
         body = 31'd0;
      end else if (ue > 13'sd127) begin
         body = {8'hFF, 23'd0};
      end else if (ue >= -13'sd126) begin
         g    = f[28];
         st   = |f[27:0];
         up   = g & (st | f[29]);
         // A carry out of the fraction steps the exponent, up to infinity.
         body = {8'(ue + 13'sd127), f[51:29]} + 31'(up);
      end else if (ue >= -13'sd150) begin
         q    = sig >> sh;
         g    = sig[sh - 6'd1];
         st   = |(sig & ((53'd1 << (sh - 6'd1)) - 53'd1));
         up   = g & (st | q[0]);
         body = 31'(q) + 31'(up);
      end else begin
         body = 31'd0;
      end
      return {s, body};
   endfunction

endpackage

### hdl/depthwise_conv1d_weight_gradient.sv
`timescale 1ns / 1ps
// Loads write the line memory when taken; a read converts a tap into the result register.
// In a gradient transaction, every tap goes through the single shared fp64 multiply-add
// datapath in 8 sequencer steps, and a tap with special operands skips ADD, LZC and NORM.
// req_stall is high while a transaction is in progress; a read also waits in its last step
// while an earlier result is still held on the result channel.
// Reset is synchronous: it restores the register defaults and marks every tap accumulator as
// zero through per-entry valid bits; the input line memory is not cleared.
module depthwise_conv1d_weight_gradient #(
   parameter int MAX_CHANNELS     = dcwg_pkg::MAX_CHANNELS_DEFAULT,
   parameter int MAX_INPUT_WIDTH  = dcwg_pkg::MAX_INPUT_WIDTH_DEFAULT,
   parameter int MAX_KERNEL_WIDTH = dcwg_pkg::MAX_KERNEL_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_position,
   input  logic [3:0]  req_channel,
   input  logic [3:0]  req_tap,
   input  logic [31:0] req_sample_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_kernel_value,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_write_data
);

   localparam int LINE_DEPTH = MAX_INPUT_WIDTH * MAX_CHANNELS;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int ACC_DEPTH  = MAX_KERNEL_WIDTH * MAX_CHANNELS;
   localparam int ACC_AW     = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;

   localparam logic [4:0]  CH_CAP    = (MAX_CHANNELS > 31) ? 5'd31 : 5'(MAX_CHANNELS);
   localparam logic [10:0] WIDTH_CAP = (MAX_INPUT_WIDTH > 2047) ? 11'd2047
                                                                : 11'(MAX_INPUT_WIDTH);
   localparam logic [4:0]  KW_CAP    = (MAX_KERNEL_WIDTH > 31) ? 5'd31
                                                               : 5'(MAX_KERNEL_WIDTH);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_CHECK = 13'b0000000000010,
      ST_READ  = 13'b0000000000100,
      ST_UNPK  = 13'b0000000001000,
      ST_MUL   = 13'b0000000010000,
      ST_ALIGN = 13'b0000000100000,
      ST_ADD   = 13'b0000001000000,
      ST_LZC   = 13'b0000010000000,
      ST_NORM  = 13'b0000100000000,
      ST_WRITE = 13'b0001000000000,
      ST_RREAD = 13'b0010000000000,
      ST_RCONV = 13'b0100000000000,
      ST_SPARE = 13'b1000000000000
   } state_type;

   // Control
   state_type   state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  chan_ff, kern_ff;
   logic [10:0] width_ff;
   logic [6:0]  stride_ff;

   // Transaction and datapath registers
   dcwg_pkg::op_type            op_ff, op_in;
   logic [9:0]                  pos_ff, pos_in;
   logic [3:0]                  ch_ff, ch_in;
   logic [3:0]                  tap_ff, tap_in;
   logic [31:0]                 val_ff, val_in;
   logic [31:0]                 rsp_value_ff, rsp_value_in;
   dcwg_pkg::fp32_unpacked_type v_ff, v_in, u_ff, u_in;
   logic [4:0]                  kx_ff, kx_in;
   logic [10:0]                 ix_ff, ix_in;
   dcwg_pkg::fp_class_type      p_cls_ff, p_cls_in;
   logic                        p_sign_ff, p_sign_in;
   logic [63:0]                 p_nan_ff, p_nan_in;
   logic [47:0]                 p_m_ff, p_m_in;
   logic [11:0]                 p_e_ff, p_e_in;
   logic                        x_sign_ff, x_sign_in;
   logic [10:0]                 x_exp_ff, x_exp_in;
   logic [55:0]                 x_m_ff, x_m_in;
   logic [55:0]                 y_m_ff, y_m_in;
   logic                        sub_ff, sub_in;
   logic [56:0]                 sum_ff, sum_in;
   logic [5:0]                  lz_ff, lz_in;
   logic [63:0]                 res_ff, res_in;

   // Memories
   logic [31:0] line_mem [LINE_DEPTH];
   logic [63:0] acc_mem [ACC_DEPTH];
   logic        acc_valid_ff [ACC_DEPTH];
   logic [31:0] line_rd_ff;
   logic [63:0] acc_rd_ff;
   logic        acc_valid_rd_ff;

   logic [LINE_AW-1:0] line_waddr, line_raddr;
   logic [ACC_AW-1:0]  acc_addr;
   logic [4:0]         acc_k;
   logic               line_we, acc_we, acc_clear;

   logic [4:0]  eff_ch, eff_kw;
   logic [10:0] eff_w;
   logic        req_fire, rsp_free;

   // Combinational datapath values
   logic [16:0] base;
   logic [17:0] last_ix;
   logic        grad_ok, read_ok, load_ok;
   logic [63:0] a_bits, b_bits;
   logic [10:0] a_e, a_ex, b_ex, y_ex, dsh;
   logic [51:0] a_f;
   logic [52:0] a_m, b_m, y_m;
   logic        a_nan, a_inf, a_zero, a_big, y_sign, a_special;
   logic [63:0] spec_bits;
   logic [55:0] y_ext, y_al;
   logic        y_st;
   logic [5:0]  lz_calc;
   logic [55:0] n_m;
   logic signed [12:0] n_e;
   logic        n_up;

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kernel_value = rsp_value_ff;
   assign req_fire         = req_valid && !req_stall;
   assign rsp_free         = !rsp_valid_ff || !rsp_stall;

   assign eff_ch = (chan_ff > CH_CAP) ? CH_CAP : chan_ff;
   assign eff_w  = (width_ff > WIDTH_CAP) ? WIDTH_CAP : width_ff;
   assign eff_kw = (kern_ff > KW_CAP) ? KW_CAP : kern_ff;

   assign load_ok = ({1'b0, req_channel} < eff_ch) && ({1'b0, req_position} < eff_w);
   assign line_we = req_fire && (dcwg_pkg::op_type'(req_operation) == dcwg_pkg::OP_LOAD)
                    && load_ok;
   assign line_waddr = LINE_AW'(req_position) * LINE_AW'(MAX_CHANNELS)
                       + LINE_AW'(req_channel);
   assign line_raddr = LINE_AW'(ix_ff) * LINE_AW'(MAX_CHANNELS) + LINE_AW'(ch_ff);
   assign acc_k      = (op_ff == dcwg_pkg::OP_READ) ? {1'b0, tap_ff} : kx_ff;
   assign acc_addr   = ACC_AW'(acc_k) * ACC_AW'(MAX_CHANNELS) + ACC_AW'(ch_ff);

   assign read_ok   = ({1'b0, ch_ff} < eff_ch) && ({1'b0, tap_ff} < eff_kw);
   assign acc_we    = (state_ff == ST_WRITE);
   assign acc_clear = (state_ff == ST_RCONV) && rsp_free && read_ok;

   // Gradient range check.
   assign base    = 17'(pos_ff) * 17'(stride_ff);
   assign last_ix = 18'(base) + 18'(eff_kw) - 18'd1;
   assign grad_ok = ({1'b0, ch_ff} < eff_ch) && (eff_kw != 5'd0) && (last_ix < 18'(eff_w));

   // Accumulator decode, product in fp64 form, special operand resolution and alignment.
   always_comb begin
      a_bits = acc_valid_rd_ff ? acc_rd_ff : 64'd0;
      a_e    = a_bits[62:52];
      a_f    = a_bits[51:0];
      a_nan  = (a_e == 11'h7FF) && (a_f != 52'd0);
      a_inf  = (a_e == 11'h7FF) && (a_f == 52'd0);
      a_zero = (a_e == 11'd0) && (a_f == 52'd0);
      a_m    = {(a_e != 11'd0), a_f};
      a_ex   = (a_e == 11'd0) ? 11'd1 : a_e;
      if (p_m_ff[47]) begin
         b_m  = {p_m_ff, 5'd0};
         b_ex = 11'(p_e_ff + 12'd1024);
      end else begin
         b_m  = {p_m_ff[46:0], 6'd0};
         b_ex = 11'(p_e_ff + 12'd1023);
      end
      b_bits = {p_sign_ff, b_ex, b_m[51:0]};

      a_special = 1'b1;
      spec_bits = a_bits;
      if (a_nan) begin
         spec_bits = a_bits | (64'd1 << 51);
      end else if (p_cls_ff == dcwg_pkg::FP_NAN) begin
         spec_bits = p_nan_ff;
      end else if (a_inf && p_cls_ff == dcwg_pkg::FP_INF && a_bits[63] != p_sign_ff) begin
         spec_bits = dcwg_pkg::FP64_DEFAULT_NAN;
      end else if (a_inf) begin
         spec_bits = a_bits;
      end else if (p_cls_ff == dcwg_pkg::FP_INF) begin
         spec_bits = {p_sign_ff, 11'h7FF, 52'd0};
      end else if (p_cls_ff == dcwg_pkg::FP_ZERO) begin
         spec_bits = a_zero ? {a_bits[63] & p_sign_ff, 63'd0} : a_bits;
      end else if (a_zero) begin
         spec_bits = b_bits;
      end else begin
         a_special = 1'b0;
      end

      a_big  = {a_ex, a_m} >= {b_ex, b_m};
      y_m    = a_big ? b_m : a_m;
      y_ex   = a_big ? b_ex : a_ex;
      y_sign = a_big ? p_sign_ff : a_bits[63];
      dsh    = (a_big ? a_ex : b_ex) - y_ex;
      y_ext  = {y_m, 3'd0};
      if (dsh >= 11'd56) begin
         y_al = 56'd0;
         y_st = |y_m;
      end else begin
         y_al = y_ext >> dsh;
         y_st = |(y_ext & ~({56{1'b1}} << dsh));
      end
   end

   // Leading zero count of the raw sum, counted from the carry position.
   always_comb begin
      lz_calc = 6'd0;
      for (int i = 0; i < 57; i++) begin
         if (sum_ff[i]) begin
            lz_calc = 6'(56 - i);
         end
      end
   end

   // Normalize and round to nearest even.
   always_comb begin
      if (lz_ff == 6'd0) begin
         n_m = {sum_ff[56:2], sum_ff[1] | sum_ff[0]};
         n_e = $signed({2'b00, x_exp_ff}) + 13'sd1;
      end else begin
         n_m = 56'(sum_ff << (lz_ff - 6'd1));
         n_e = $signed({2'b00, x_exp_ff}) - $signed({7'd0, lz_ff - 6'd1});
      end
      n_up = n_m[2] & (n_m[1] | n_m[0] | n_m[3]);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      ch_in        = ch_ff;
      tap_in       = tap_ff;
      val_in       = val_ff;
      rsp_value_in = rsp_value_ff;
      v_in         = v_ff;
      u_in         = u_ff;
      kx_in        = kx_ff;
      ix_in        = ix_ff;
      p_cls_in     = p_cls_ff;
      p_sign_in    = p_sign_ff;
      p_nan_in     = p_nan_ff;
      p_m_in       = p_m_ff;
      p_e_in       = p_e_ff;
      x_sign_in    = x_sign_ff;
      x_exp_in     = x_exp_ff;
      x_m_in       = x_m_ff;
      y_m_in       = y_m_ff;
      sub_in       = sub_ff;
      sum_in       = sum_ff;
      lz_in        = lz_ff;
      res_in       = res_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = dcwg_pkg::op_type'(req_operation);
               pos_in = req_position;
               ch_in  = req_channel;
               tap_in = req_tap;
               val_in = req_sample_value;
               case (dcwg_pkg::op_type'(req_operation))
                  dcwg_pkg::OP_GRAD: state_in = ST_CHECK;
                  dcwg_pkg::OP_READ: state_in = ST_RREAD;
                  default:           state_in = ST_IDLE;
               endcase
            end
         end
         ST_CHECK: begin
            v_in  = dcwg_pkg::fp32_unpack(val_ff);
            kx_in = 5'd0;
            ix_in = 11'(base);
            state_in = grad_ok ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_UNPK;
         end
         ST_UNPK: begin
            u_in     = dcwg_pkg::fp32_unpack(line_rd_ff);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            p_sign_in = u_ff.sign ^ v_ff.sign;
            p_m_in    = u_ff.sig * v_ff.sig;
            p_e_in    = {{2{u_ff.exp[9]}}, u_ff.exp} + {{2{v_ff.exp[9]}}, v_ff.exp};
            if (u_ff.cls == dcwg_pkg::FP_NAN) begin
               p_nan_in = u_ff.nan_bits;
            end else if (v_ff.cls == dcwg_pkg::FP_NAN) begin
               p_nan_in = v_ff.nan_bits;
            end else begin
               p_nan_in = dcwg_pkg::FP64_DEFAULT_NAN;
            end
            if (u_ff.cls == dcwg_pkg::FP_NAN || v_ff.cls == dcwg_pkg::FP_NAN
                || (u_ff.cls == dcwg_pkg::FP_INF && v_ff.cls == dcwg_pkg::FP_ZERO)
                || (u_ff.cls == dcwg_pkg::FP_ZERO && v_ff.cls == dcwg_pkg::FP_INF)) begin
               p_cls_in = dcwg_pkg::FP_NAN;
            end else if (u_ff.cls == dcwg_pkg::FP_INF || v_ff.cls == dcwg_pkg::FP_INF) begin
               p_cls_in = dcwg_pkg::FP_INF;
            end else if (u_ff.cls == dcwg_pkg::FP_ZERO
                         || v_ff.cls == dcwg_pkg::FP_ZERO) begin
               p_cls_in = dcwg_pkg::FP_ZERO;
            end else begin
               p_cls_in = dcwg_pkg::FP_NORMAL;
            end
            state_in = ST_ALIGN;
         end
         ST_ALIGN: begin
            x_sign_in = a_big ? a_bits[63] : p_sign_ff;
            x_exp_in  = a_big ? a_ex : b_ex;
            x_m_in    = {(a_big ? a_m : b_m), 3'd0};
            y_m_in    = {y_al[55:1], y_al[0] | y_st};
            sub_in    = (a_big ? a_bits[63] : p_sign_ff) ^ y_sign;
            res_in    = spec_bits;
            state_in  = a_special ? ST_WRITE : ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sub_ff ? ({1'b0, x_m_ff} - {1'b0, y_m_ff})
                              : ({1'b0, x_m_ff} + {1'b0, y_m_ff});
            state_in = ST_LZC;
         end
         ST_LZC: begin
            lz_in    = lz_calc;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            // Exact cancellation gives positive zero under round to nearest.
            if (sum_ff == 57'd0) begin
               res_in = 64'd0;
            end else if (n_e >= 13'sd2047) begin
               res_in = {x_sign_ff, 11'h7FF, 52'd0};
            end else if (n_e <= 13'sd0) begin
               res_in = {x_sign_ff, 63'd0};
            end else begin
               res_in = {x_sign_ff, 11'(n_e), n_m[54:3]} + 64'(n_up);
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (kx_ff == eff_kw - 5'd1) begin
               state_in = ST_IDLE;
            end else begin
               kx_in    = kx_ff + 5'd1;
               ix_in    = ix_ff + 11'd1;
               state_in = ST_READ;
            end
         end
         ST_RREAD: begin
            state_in = ST_RCONV;
         end
         ST_RCONV: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = read_ok ? dcwg_pkg::fp64_to_fp32(a_bits) : 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chan_ff      <= 5'd1;
         width_ff     <= 11'd1024;
         kern_ff      <= 5'd1;
         stride_ff    <= 7'd1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (dcwg_pkg::csr_index_type'(csr_index))
               dcwg_pkg::CSR_CHANNELS: chan_ff   <= csr_write_data[4:0];
               dcwg_pkg::CSR_WIDTH:    width_ff  <= csr_write_data;
               dcwg_pkg::CSR_KERNEL:   kern_ff   <= csr_write_data[4:0];
               dcwg_pkg::CSR_STRIDE:   stride_ff <= csr_write_data[6:0];
               default:                chan_ff   <= chan_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      ch_ff        <= ch_in;
      tap_ff       <= tap_in;
      val_ff       <= val_in;
      rsp_value_ff <= rsp_value_in;
      v_ff         <= v_in;
      u_ff         <= u_in;
      kx_ff        <= kx_in;
      ix_ff        <= ix_in;
      p_cls_ff     <= p_cls_in;
      p_sign_ff    <= p_sign_in;
      p_nan_ff     <= p_nan_in;
      p_m_ff       <= p_m_in;
      p_e_ff       <= p_e_in;
      x_sign_ff    <= x_sign_in;
      x_exp_ff     <= x_exp_in;
      x_m_ff       <= x_m_in;
      y_m_ff       <= y_m_in;
      sub_ff       <= sub_in;
      sum_ff       <= sum_in;
      lz_ff        <= lz_in;
      res_ff       <= res_in;
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= req_sample_value;
      end
      line_rd_ff <= line_mem[line_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_addr] <= res_ff;
      end
      acc_rd_ff <= acc_mem[acc_addr];
   end

   // An accumulator entry that is not valid reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACC_DEPTH; i++) begin
            acc_valid_ff[i] <= 1'b0;
         end
         acc_valid_rd_ff <= 1'b0;
      end else begin
         if (acc_we) begin
            acc_valid_ff[acc_addr] <= 1'b1;
         end else if (acc_clear) begin
            acc_valid_ff[acc_addr] <= 1'b0;
         end
         acc_valid_rd_ff <= acc_valid_ff[acc_addr];
      end
   end

endmodule
